FILE: rtl/fftlb_pkg.sv
// fftlb_pkg: shared codes and default sizes for the lifting-butterfly FFT block.
// No dependencies; imported by radix2_fft_lifting_butterflies.

package fftlb_pkg;

   localparam int DEF_MAX_POINTS   = 1024;
   localparam int DEF_TABLE_DEPTH  = 1024;
   localparam int DEF_SAMPLE_WIDTH = 32;
   localparam int DEF_COEF_WIDTH   = 16;

   // width of stage / log2 length counters (covers log2 of 65536)
   localparam int LW = 5;

   // request operations
   localparam logic [1:0] OP_WRITE_SAMPLE = 2'd0;
   localparam logic [1:0] OP_WRITE_TABLE  = 2'd1;
   localparam logic [1:0] OP_RUN          = 2'd2;
   localparam logic [1:0] OP_READ         = 2'd3;

   // response status
   localparam logic [1:0] ST_READ_OK = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;

   // configuration register indexes
   localparam logic REG_LOG2_POINTS  = 1'b0;
   localparam logic REG_TABLE_STRIDE = 1'b1;

   // lifting shear phases
   localparam logic [1:0] PH_V = 2'd0;
   localparam logic [1:0] PH_U = 2'd1;
   localparam logic [1:0] PH_W = 2'd2;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_RDWAIT = 11'b000_0000_0010,
      S_RDA    = 11'b000_0000_0100,
      S_RDB    = 11'b000_0000_1000,
      S_GETB   = 11'b000_0001_0000,
      S_MLO    = 11'b000_0010_0000,
      S_MHI    = 11'b000_0100_0000,
      S_MRND   = 11'b000_1000_0000,
      S_ACC    = 11'b001_0000_0000,
      S_WRA    = 11'b010_0000_0000,
      S_WRB    = 11'b100_0000_0000
   } state_type;

endpackage

FILE: rtl/radix2_fft_lifting_butterflies.sv
// radix2_fft_lifting_butterflies: in-place radix-2 FFT with lifting rotations.
// Depends on fftlb_pkg (codes, state type, default sizes).
//
//  channel  dir  handshake                  carries
//  req_*    in   req_valid / req_ready      operation, index, sample, table entry
//  rsp_*    out  rsp_valid / rsp_ready      status, read-back sample
//  APB      in   psel, penable, pready=1    log2_points (0x0), table_stride (0x4)
//
// Transactions: sample and table writes complete on acceptance; a read's sample is
// registered from the store, then into the response registers. A run walks every
// butterfly of every stage through one sample memory port, N/2 butterflies per stage;
// a rotated butterfly runs three shears through one shared multiplier.
// Reset is synchronous; the stores hold garbage until written. req_ready is low for the
// whole run; a waiting result never blocks acceptance when rsp_ready is high.

module radix2_fft_lifting_butterflies import fftlb_pkg::*; #(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [9:0]         req_index,
   input  logic signed [31:0] req_real_in,
   input  logic signed [31:0] req_imag_in,
   input  logic signed [15:0] req_sine_in,
   input  logic signed [15:0] req_tangent_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_real_out,
   output logic signed [31:0] rsp_imag_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int SW       = SAMPLE_WIDTH;
   localparam int CW       = COEF_WIDTH;
   localparam int AW       = $clog2(MAX_POINTS);
   localparam int TWW      = $clog2(TABLE_DEPTH);
   localparam int LOG2_MAX = $clog2(MAX_POINTS + 1) - 1;
   localparam int NW       = AW + 1;
   localparam int QW       = AW + 4;
   localparam int CKW      = NW + 4;
   localparam int FRAC     = CW - 2;
   localparam int H        = SW / 2;
   localparam int HW       = SW - H;
   localparam int PRW      = SW + CW;
   localparam int MW       = SW + 3;
   localparam int EW       = ((SW > 32) ? SW : 32) + 2;
   localparam int CEW      = ((CW > 16) ? CW : 16) + 1;
   localparam int IXW0     = (AW > TWW) ? AW : TWW;
   localparam int IXW      = ((IXW0 > 10) ? IXW0 : 10) + 1;

   localparam logic signed [EW-1:0]  SMAX  = EW'({(SW-1){1'b1}});
   localparam logic signed [EW-1:0]  SMIN  = ~SMAX;
   localparam logic signed [EW-1:0]  MAX32 = EW'(32'h7FFF_FFFF);
   localparam logic signed [EW-1:0]  MIN32 = ~MAX32;
   localparam logic signed [CEW-1:0] CMAX  = CEW'({(CW-1){1'b1}});
   localparam logic signed [CEW-1:0] CMIN  = ~CMAX;
   localparam logic [MW-1:0]         MMAX  = MW'({(SW-1){1'b1}});

   // saturating helpers
   function automatic logic signed [SW-1:0] sat_s(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
      return r[SW-1:0];
   endfunction

   function automatic logic signed [31:0] sat_32(input logic signed [SW-1:0] v);
      logic signed [EW-1:0] e;
      logic signed [EW-1:0] r;
      e = EW'(v);
      r = (e > MAX32) ? MAX32 : ((e < MIN32) ? MIN32 : e);
      return r[31:0];
   endfunction

   function automatic logic signed [CW-1:0] sat_c(input logic signed [15:0] v);
      logic signed [CEW-1:0] e;
      logic signed [CEW-1:0] r;
      e = CEW'(v);
      r = (e > CMAX) ? CMAX : ((e < CMIN) ? CMIN : e);
      return r[CW-1:0];
   endfunction

   // ---------------------------------------------------------------- config regs
   logic [3:0] log2_ff, log2_in, stride_ff, stride_in;
   logic       cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_TABLE_STRIDE) ? 32'(stride_ff) : 32'(log2_ff);

   always_comb begin
      log2_in   = log2_ff;
      stride_in = stride_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_LOG2_POINTS) log2_in = pwdata[3:0];
         else stride_in = pwdata[3:0];
      end
   end

   // ---------------------------------------------------------------- memories
   logic          mwe;
   logic [AW-1:0] mwaddr, mraddr;
   logic [2*SW-1:0] mwdata, mrdata_ff;
   logic [2*SW-1:0] smem [MAX_POINTS];

   logic           twe;
   logic [TWW-1:0] twaddr;
   logic [2*CW-1:0] twdata, trdata_ff;
   logic [2*CW-1:0] tmem [TABLE_DEPTH];

   // ---------------------------------------------------------------- sequencer state
   state_type st_ff, st_in;
   logic [LW-1:0] lp_ff, lp_in, sd_ff, sd_in;
   logic [NW-1:0] n_ff, n_in, d2_ff, d2_in, j_ff, j_in, a_ff, a_in;
   logic [TWW-1:0] tw_ff, tw_in;
   logic [QW-1:0]  q_ff, q_in;
   logic [1:0]     ph_ff, ph_in;
   logic           rd_ok_ff, rd_ok_in;

   logic signed [SW-1:0] ar_ff, ar_in, ai_ff, ai_in, br_ff, br_in, bi_ff, bi_in;
   logic signed [SW-1:0] tr_ff, tr_in, ti_ff, ti_in, v_ff, v_in, u_ff, u_in, p_ff, p_in;
   logic [PRW-1:0] acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;

   // ---------------------------------------------------------------- decode
   logic           req_fire;
   logic [IXW-1:0] idx_w;
   logic           idx_ok, tidx_ok;
   logic [LW-1:0]  lp_eff;
   logic [NW-1:0]  n_eff;
   logic [CKW-1:0] chk_prod;
   logic           too_small;

   assign req_ready = (st_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign idx_w     = IXW'(req_index);
   assign idx_ok    = idx_w < IXW'(MAX_POINTS);
   assign tidx_ok   = idx_w < IXW'(TABLE_DEPTH);
   assign lp_eff    = (LW'(log2_ff) > LW'(LOG2_MAX)) ? LW'(LOG2_MAX) : LW'(log2_ff);
   assign n_eff     = NW'(1) << lp_eff;
   assign chk_prod  = CKW'(stride_ff) * CKW'((n_eff >> 2) - NW'(1));
   assign too_small = (lp_eff >= LW'(3)) && (32'(chk_prod) >= 32'(TABLE_DEPTH));

   // butterfly kind within the stage: j = 0 plain, j = d2/2 quarter turn,
   // below that a rotation, above it the mirrored rotation
   logic [NW-1:0] d4;
   logic          is_plain, is_quarter, rot1;
   logic [AW-1:0] b_addr;

   assign d4         = d2_ff >> 1;
   assign is_plain   = (j_ff == '0);
   assign is_quarter = (j_ff == d4);
   assign rot1       = (j_ff < d4);
   assign b_addr     = AW'(a_ff + d2_ff);

   // memory read words
   logic signed [SW-1:0] rd_re, rd_im;
   logic signed [CW-1:0] sl, tl;
   assign rd_re = mrdata_ff[SW-1:0];
   assign rd_im = mrdata_ff[2*SW-1:SW];
   assign sl    = trdata_ff[2*CW-1:CW];
   assign tl    = trdata_ff[CW-1:0];

   // ---------------------------------------------------------------- shared multiplier
   // |x| * |c| in two half-width partial products, then round and saturate.
   logic signed [SW-1:0] mul_x;
   logic signed [CW-1:0] mul_c;
   logic [SW-1:0]        mx;
   logic [CW-1:0]        mc;
   logic                 neg;
   logic [H+CW-1:0]      lo_prod;
   logic [HW+CW-1:0]     hi_prod;
   logic [PRW:0]         rnd;
   logic [MW-1:0]        m;
   logic signed [SW-1:0] pr;

   always_comb begin
      case (ph_ff)
         PH_V:    mul_x = rot1 ? br_ff : bi_ff;
         PH_U:    mul_x = v_ff;
         default: mul_x = u_ff;
      endcase
   end
   assign mul_c   = (ph_ff == PH_U) ? sl : tl;
   assign mx      = mul_x[SW-1] ? SW'(-mul_x) : SW'(mul_x);
   assign mc      = mul_c[CW-1] ? CW'(-mul_c) : CW'(mul_c);
   assign neg     = mul_x[SW-1] ^ mul_c[CW-1];
   assign lo_prod = mx[H-1:0] * mc;
   assign hi_prod = mx[SW-1:H] * mc;
   assign rnd     = (PRW+1)'(acc_ff) + ((PRW+1)'(1) << (FRAC - 1));
   assign m       = MW'(rnd >> FRAC);

   always_comb begin
      if (neg) begin
         if (m > MMAX + MW'(1)) pr = SMIN[SW-1:0];
         else pr = SW'(-m);
      end else begin
         if (m > MMAX) pr = SMAX[SW-1:0];
         else pr = SW'(m);
      end
   end

   // ---------------------------------------------------------------- next state
   logic [NW:0]   a_nx;
   logic [NW-1:0] j1;
   assign a_nx = (NW+1)'(a_ff) + ((NW+1)'(d2_ff) << 1);
   assign j1   = j_ff + NW'(1);

   always_comb begin
      st_in = st_ff;
      lp_in = lp_ff; sd_in = sd_ff; n_in = n_ff; d2_in = d2_ff;
      j_in = j_ff; a_in = a_ff; tw_in = tw_ff; q_in = q_ff; ph_in = ph_ff;
      rd_ok_in = rd_ok_ff;
      ar_in = ar_ff; ai_in = ai_ff; br_in = br_ff; bi_in = bi_ff;
      tr_in = tr_ff; ti_in = ti_ff; v_in = v_ff; u_in = u_ff; p_in = p_ff;
      acc_in = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_re_in     = rsp_re_ff;
      rsp_im_in     = rsp_im_ff;
      mwe    = 1'b0;
      mwaddr = a_ff[AW-1:0];
      mwdata = {sat_s(EW'(ai_ff) + EW'(ti_ff)), sat_s(EW'(ar_ff) + EW'(tr_ff))};
      mraddr = a_ff[AW-1:0];
      twe    = 1'b0;
      twaddr = idx_w[TWW-1:0];
      twdata = {sat_c(req_sine_in), sat_c(req_tangent_in)};

      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_operation)
                  OP_WRITE_SAMPLE: begin
                     mwe    = idx_ok;
                     mwaddr = idx_w[AW-1:0];
                     mwdata = {sat_s(EW'(req_imag_in)), sat_s(EW'(req_real_in))};
                  end
                  OP_WRITE_TABLE: begin
                     twe = tidx_ok;
                  end
                  OP_RUN: begin
                     if (lp_eff == '0 || too_small) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = too_small ? ST_REJECT : ST_DONE;
                        rsp_re_in     = '0;
                        rsp_im_in     = '0;
                     end else begin
                        lp_in = lp_eff;
                        n_in  = n_eff;
                        sd_in = LW'(1);
                        d2_in = NW'(1);
                        j_in  = '0;
                        a_in  = '0;
                        tw_in = '0;
                        q_in  = QW'(stride_ff) << (lp_eff - LW'(1));
                        st_in = S_RDA;
                     end
                  end
                  OP_READ: begin
                     mraddr   = idx_w[AW-1:0];
                     rd_ok_in = idx_ok;
                     st_in    = S_RDWAIT;
                  end
                  default: ;
               endcase
            end
         end
         S_RDWAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_READ_OK;
            rsp_re_in     = rd_ok_ff ? sat_32(rd_re) : '0;
            rsp_im_in     = rd_ok_ff ? sat_32(rd_im) : '0;
            st_in         = S_IDLE;
         end
         S_RDA: begin
            st_in = S_RDB;
         end
         S_RDB: begin
            mraddr = b_addr;
            ar_in  = rd_re;
            ai_in  = rd_im;
            st_in  = S_GETB;
         end
         S_GETB: begin
            br_in = rd_re;
            bi_in = rd_im;
            ph_in = PH_V;
            if (is_plain) begin
               tr_in = rd_re;
               ti_in = rd_im;
               st_in = S_WRA;
            end else if (is_quarter) begin
               tr_in = sat_s(-EW'(rd_im));
               ti_in = rd_re;
               st_in = S_WRA;
            end else begin
               st_in = S_MLO;
            end
         end
         S_MLO: begin
            acc_in = PRW'(lo_prod);
            st_in  = S_MHI;
         end
         S_MHI: begin
            acc_in = acc_ff + (PRW'(hi_prod) << H);
            st_in  = S_MRND;
         end
         S_MRND: begin
            p_in  = pr;
            st_in = S_ACC;
         end
         S_ACC: begin
            case (ph_ff)
               PH_V: begin
                  // first shear: v = y + t*x
                  v_in  = rot1 ? sat_s(EW'(bi_ff) + EW'(p_ff))
                               : sat_s(EW'(br_ff) - EW'(p_ff));
                  ph_in = PH_U;
                  st_in = S_MLO;
               end
               PH_U: begin
                  // second shear: u = x - s*v
                  u_in  = rot1 ? sat_s(EW'(br_ff) - EW'(p_ff))
                               : sat_s(-EW'(bi_ff) - EW'(p_ff));
                  ph_in = PH_W;
                  st_in = S_MLO;
               end
               default: begin
                  // third shear: w = t*u + v
                  tr_in = u_ff;
                  ti_in = sat_s(EW'(p_ff) + EW'(v_ff));
                  st_in = S_WRA;
               end
            endcase
         end
         S_WRA: begin
            mwe   = 1'b1;
            st_in = S_WRB;
         end
         S_WRB: begin
            mwe    = 1'b1;
            mwaddr = b_addr;
            mwdata = {sat_s(EW'(ai_ff) - EW'(ti_ff)), sat_s(EW'(ar_ff) - EW'(tr_ff))};
            st_in  = S_RDA;
            if (a_nx < (NW+1)'(n_ff)) begin
               a_in = a_nx[NW-1:0];
            end else if (j1 < d2_ff) begin
               j_in  = j1;
               a_in  = j1;
               tw_in = (j1 == d4) ? '0 : tw_ff + q_ff[TWW-1:0];
            end else if (sd_ff == lp_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_re_in     = '0;
               rsp_im_in     = '0;
               st_in         = S_IDLE;
            end else begin
               sd_in = sd_ff + LW'(1);
               d2_in = d2_ff << 1;
               j_in  = '0;
               a_in  = '0;
               tw_in = '0;
               q_in  = q_ff >> 1;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         log2_ff      <= 4'd10;
         stride_ff    <= 4'd1;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         log2_ff      <= log2_in;
         stride_ff    <= stride_in;
      end
   end

   always_ff @(posedge clock) begin
      lp_ff <= lp_in; sd_ff <= sd_in; n_ff <= n_in; d2_ff <= d2_in;
      j_ff <= j_in; a_ff <= a_in; tw_ff <= tw_in; q_ff <= q_in; ph_ff <= ph_in;
      rd_ok_ff <= rd_ok_in;
      ar_ff <= ar_in; ai_ff <= ai_in; br_ff <= br_in; bi_ff <= bi_in;
      tr_ff <= tr_in; ti_ff <= ti_in; v_ff <= v_in; u_ff <= u_in; p_ff <= p_in;
      acc_ff <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_re_ff     <= rsp_re_in;
      rsp_im_ff     <= rsp_im_in;
   end

   always_ff @(posedge clock) begin
      if (mwe) smem[mwaddr] <= mwdata;
      mrdata_ff <= smem[mraddr];
   end

   always_ff @(posedge clock) begin
      if (twe) tmem[twaddr] <= twdata;
      trdata_ff <= tmem[tw_ff];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_real_out = rsp_re_ff;
   assign rsp_imag_out = rsp_im_ff;

   // ---------------------------------------------------------------- assertions
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_ready)
      else $error("request accepted while a run or read is in progress");

   a_idle_write_src: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE && mwe) |-> (req_fire && req_operation == OP_WRITE_SAMPLE))
      else $error("sample store written in idle without a write transaction");

   a_j_in_span: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_GETB) |-> (j_ff < d2_ff))
      else $error("butterfly offset beyond half span");

   a_wrb_next: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_WRB) |=> (st_ff == S_RDA || st_ff == S_IDLE))
      else $error("bad sequencer step after second write");

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking testbench for radix2_fft_lifting_butterflies.
// Depends on fftlb_pkg (operation, status and register codes) and the RTL top level.
`timescale 1ns / 1ps

module tb;
   import fftlb_pkg::*;

   localparam int       NPTS        = 1024;  // sample store depth
   localparam int       NTAB        = 1024;  // sine / tangent table depth
   localparam int       ITEM_TARGET = 1400;
   localparam int       LONG_HOLD   = 300;
   localparam longint   CYCLE_LIMIT = 20000000;
   localparam longint   SMAX        = 64'sd2147483647;
   localparam longint   SMIN        = -64'sd2147483648;

   // one transaction on the response channel
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] re;
      logic signed [31:0] im;
   } fft_rsp_t;

   // one row of the directed stimulus table
   typedef struct {
      logic [1:0]         op;
      logic [9:0]         idx;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic signed [15:0] sn;
      logic signed [15:0] tn;
      bit                 typed;   // expected response typed in below
      fft_rsp_t           rsp;
   } fft_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = OP_READ;
   logic [9:0]         req_index = '0;
   logic signed [31:0] req_real_in = '0;
   logic signed [31:0] req_imag_in = '0;
   logic signed [15:0] req_sine_in = '0;
   logic signed [15:0] req_tangent_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_real_out;
   logic signed [31:0] rsp_imag_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   radix2_fft_lifting_butterflies i_dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the stores and the two registers.
   // ---------------------------------------------------------------------
   longint     smp_re [NPTS];
   longint     smp_im [NPTS];
   longint     sin_tab [NTAB];
   longint     tan_tab [NTAB];
   bit         smp_written [NPTS];
   bit         tab_written [NTAB];
   logic [3:0] cfg_log2 = 4'd10;
   logic [3:0] cfg_stride = 4'd1;

   fft_rsp_t   rsp_expected_q [$];
   int         errors = 0;
   longint     cycles = 0;
   int         n_items = 0, n_runs = 0, n_rejects = 0, n_reads = 0, n_settings = 0;
   int         stall_left = 0;
   bit         long_hold_req = 0;

   function automatic longint sat32(longint v);
      return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
   endfunction

   // sample * Q2.14 coef, rounded half away from zero, saturated
   function automatic longint coef_mul(longint x, longint c);
      longint p, m;
      p = x * c;
      m = p < 0 ? -p : p;
      m = (m + 64'sd8192) >>> 14;
      return sat32(p < 0 ? -m : m);
   endfunction

   function automatic void butterfly(int unsigned a, int unsigned b, longint tr, longint ti);
      longint ar, ai;
      ar = smp_re[a];
      ai = smp_im[a];
      smp_re[b] = sat32(ar - tr);
      smp_im[b] = sat32(ai - ti);
      smp_re[a] = sat32(ar + tr);
      smp_im[a] = sat32(ai + ti);
   endfunction

   function automatic int unsigned eff_points();
      int unsigned lp;
      lp = cfg_log2;
      while (lp > 0 && (1 << lp) > NPTS) lp--;
      return 1 << lp;
   endfunction

   function automatic bit table_too_small(int unsigned n);
      return n >= 8 && cfg_stride * (n / 4 - 1) >= NTAB;
   endfunction

   // whole in-place transform; returns the response status
   function automatic logic [1:0] fft_transform();
      int unsigned n, half, q, q2, d, d2, d4, a, b, av, bv, t;
      longint xr, xi, sl, tl, v, u, w;
      n = eff_points();
      half = n / 2;
      if (table_too_small(n)) return ST_REJECT;
      for (int unsigned c = 0; c < half; c++)
         butterfly(2 * c, 2 * c + 1, smp_re[2 * c + 1], smp_im[2 * c + 1]);
      q = cfg_stride * half;
      q2 = half;
      d = 2;
      while (d < n) begin
         q2 /= 2;
         q /= 2;
         d2 = d;
         d = 2 * d2;
         d4 = d2 / 2;
         a = 0;
         // plain and quarter-turn butterflies
         for (int unsigned c = 0; c < q2; c++) begin
            b = a + d2; av = a + d4; bv = b + d4;
            xr = smp_re[bv];
            xi = smp_im[bv];
            butterfly(a, b, smp_re[b], smp_im[b]);
            butterfly(av, bv, sat32(-xi), xr);
            a += d;
         end
         // rotated butterflies, three shears each
         t = q;
         for (int unsigned j = 1; j < d4; j++) begin
            sl = t < NTAB ? sin_tab[t] : 0;
            tl = t < NTAB ? tan_tab[t] : 0;
            a = j;
            for (int unsigned c = 0; c < q2; c++) begin
               b = a + d2; av = a + d4; bv = b + d4;
               v = sat32(smp_im[b] + coef_mul(smp_re[b], tl));
               u = sat32(smp_re[b] - coef_mul(v, sl));
               w = sat32(coef_mul(u, tl) + v);
               butterfly(a, b, u, w);
               v = sat32(smp_re[bv] - coef_mul(smp_im[bv], tl));
               u = sat32(-smp_im[bv] - coef_mul(v, sl));
               w = sat32(coef_mul(u, tl) + v);
               butterfly(av, bv, u, w);
               a += d;
            end
            t += q;
         end
      end
      return ST_DONE;
   endfunction

   // advance the predictor by one accepted transaction; 1 when a response follows
   function automatic bit fft_predict(logic [1:0] op, logic [9:0] idx,
                                      logic signed [31:0] re, logic signed [31:0] im,
                                      logic signed [15:0] sn, logic signed [15:0] tn,
                                      output fft_rsp_t rsp);
      rsp = '0;
      case (op)
         OP_WRITE_SAMPLE: begin
            smp_re[idx] = re;
            smp_im[idx] = im;
            smp_written[idx] = 1;
            return 0;
         end
         OP_WRITE_TABLE: begin
            sin_tab[idx] = sn;
            tan_tab[idx] = tn;
            tab_written[idx] = 1;
            return 0;
         end
         OP_RUN: begin
            rsp.status = fft_transform();
            return 1;
         end
         default: begin
            rsp.status = ST_READ_OK;
            rsp.re = smp_re[idx][31:0];
            rsp.im = smp_im[idx][31:0];
            return 1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: random gap, then hold valid until accepted.
   // ---------------------------------------------------------------------
   task automatic send_req(logic [1:0] op, logic [9:0] idx,
                           logic signed [31:0] re, logic signed [31:0] im,
                           logic signed [15:0] sn, logic signed [15:0] tn,
                           bit typed = 0, fft_rsp_t typed_rsp = '0, int gap = -1);
      fft_rsp_t pred;
      if (gap < 0) gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_index      <= idx;
      req_real_in    <= re;
      req_imag_in    <= im;
      req_sine_in    <= sn;
      req_tangent_in <= tn;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (fft_predict(op, idx, re, im, sn, tn, pred))
         rsp_expected_q.push_back(typed ? typed_rsp : pred);
      if (op == OP_RUN) begin
         n_runs++;
         if (pred.status == ST_REJECT) n_rejects++;
      end
      if (op == OP_READ) n_reads++;
      n_items++;
   endtask

   // drop valid and wait until every pending response has drained
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_expected_q.size() != 0) @(posedge clock);
      // a trailing write may still be in flight
      repeat (8) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle
   task automatic csr_write(logic reg_idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_idx == REG_LOG2_POINTS) cfg_log2 = value[3:0];
      else cfg_stride = value[3:0];
   endtask

   task automatic apply_setting(logic [3:0] lg, logic [3:0] st);
      // upper bits are junk; only the low nibble is stored
      csr_write(REG_LOG2_POINTS, {$urandom} << 4 | lg);
      csr_write(REG_TABLE_STRIDE, {$urandom} << 4 | st);
      n_settings++;
   endtask

   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(0, 2000)) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 4))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return $urandom;
      endcase
   endfunction

   // every store entry that the next run touches gets written first
   task automatic fill_for_run();
      int unsigned n, tmax;
      n = eff_points();
      if (table_too_small(n)) return;
      for (int unsigned i = 0; i < n; i++)
         if (!smp_written[i])
            send_req(OP_WRITE_SAMPLE, i, pick_sample(), pick_sample(), 0, 0);
      tmax = cfg_stride * n / 4;
      if (tmax > NTAB - 1) tmax = NTAB - 1;
      for (int unsigned i = 0; i <= tmax; i++)
         if (!tab_written[i])
            send_req(OP_WRITE_TABLE, i, 0, 0, pick_coef(), pick_coef());
   endtask

   task automatic random_item();
      int unsigned n, idx;
      n = eff_points();
      idx = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
         0, 1, 2: send_req(OP_WRITE_SAMPLE, $urandom_range(0, 1) ? idx : $urandom,
                           pick_sample(), pick_sample(), $urandom, $urandom);
         3: send_req(OP_WRITE_TABLE, $urandom, $urandom, $urandom, pick_coef(), pick_coef());
         4: begin
            fill_for_run();
            send_req(OP_RUN, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
         default: begin
            if (!smp_written[idx])
               send_req(OP_WRITE_SAMPLE, idx, pick_sample(), pick_sample(), 0, 0);
            else
               send_req(OP_READ, idx, $urandom, $urandom, $urandom, $urandom);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall per transaction, one long hold on demand.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      fft_rsp_t exp_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected_q.size() == 0) begin
               $error("unexpected response transaction status=%0d", rsp_status);
               errors++;
            end else begin
               exp_rsp = rsp_expected_q.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
                  errors++;
               end
               if (rsp_real_out !== exp_rsp.re) begin
                  $error("real_out: expected %0d, got %0d", exp_rsp.re, rsp_real_out);
                  errors++;
               end
               if (rsp_imag_out !== exp_rsp.im) begin
                  $error("imag_out: expected %0d, got %0d", exp_rsp.im, rsp_imag_out);
                  errors++;
               end
            end
            stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
         end
         if (long_hold_req) begin
            stall_left = LONG_HOLD;
            long_hold_req = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed table (log2_points 1, stride 1): extremes, every operation,
   // index extremes, a two-point run whose results saturate.
   // ---------------------------------------------------------------------
   fft_row_t directed [] = '{
      '{OP_WRITE_SAMPLE, 10'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sd0, 0, '0},
      '{OP_WRITE_SAMPLE, 10'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, 0, '0},
      '{OP_READ, 10'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1,
        '{ST_READ_OK, 32'sh7FFF_FFFF, 32'sh8000_0000}},
      '{OP_READ, 10'd1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1,
        '{ST_READ_OK, 32'sh8000_0000, 32'sh7FFF_FFFF}},
      '{OP_WRITE_TABLE, 10'd0, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh8000, 0, '0},
      '{OP_WRITE_TABLE, 10'd1023, 32'sd0, 32'sd0, 16'sh8000, 16'sh7FFF, 0, '0},
      '{OP_WRITE_SAMPLE, 10'd1023, 32'sd0, -32'sd1, 16'sd0, 16'sd0, 0, '0},
      '{OP_READ, 10'd1023, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1,
        '{ST_READ_OK, 32'sd0, -32'sd1}},
      '{OP_RUN, 10'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1, '{ST_DONE, 32'sd0, 32'sd0}},
      // max+min = -1, max-min saturates
      '{OP_READ, 10'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1, '{ST_READ_OK, -32'sd1, -32'sd1}},
      '{OP_READ, 10'd1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1,
        '{ST_READ_OK, 32'sh7FFF_FFFF, 32'sh8000_0000}},
      '{OP_RUN, 10'd1023, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 0, '0},
      '{OP_READ, 10'd1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 0, '0}
   };

   // register settings walked first: extremes, length one, stride zero, reject,
   // and last the clamp of an oversized length, whose fill is the largest
   logic [3:0] setting_lg [] = '{4'd3, 4'd4, 4'd0, 4'd10, 4'd5, 4'd2, 4'd6, 4'd8, 4'd15};
   logic [3:0] setting_st [] = '{4'd1, 4'd0, 4'd7, 4'd8, 4'd15, 4'd3, 4'd2, 4'd1, 4'd1};

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_setting(4'd1, 4'd1);
      foreach (directed[i])
         send_req(directed[i].op, directed[i].idx, directed[i].re, directed[i].im,
                  directed[i].sn, directed[i].tn, directed[i].typed, directed[i].rsp);
      drain();

      phase = 0;
      while (n_items < ITEM_TARGET) begin
         if (phase < setting_lg.size())
            apply_setting(setting_lg[phase], setting_st[phase]);
         else
            // mostly short transforms so runs stay cheap
            apply_setting($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 5),
                          $urandom);
         // one phase: receiver holds off while the sender keeps offering reads
         if (phase == 2) begin
            fill_for_run();
            send_req(OP_RUN, 0, 0, 0, 0, 0);
            long_hold_req = 1;
            for (int k = 0; k < 40; k++)
               send_req(OP_READ, $urandom_range(0, eff_points() - 1), 0, 0, 0, 0, 0, '0, 0);
         end
         repeat ($urandom_range(20, 60)) random_item();
         drain();
         phase++;
      end

      while (rsp_expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d transactions over %0d register settings", n_items,
               n_settings);
      $display("%0d transforms (%0d rejected), %0d sample reads", n_runs, n_rejects, n_reads);
      if (errors == 0 && rsp_expected_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
